[rtl/alol_pkg.sv]
// Package for the anti-diagonal longest-ones-run core: shared types and constants.
package alol_pkg;

   localparam int RUN_W = 7;
   localparam int SIZE_W = 7;
   localparam logic [RUN_W-1:0] RUN_CAP = 7'd127;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

   typedef struct packed {
      logic top_row;
      logic last_col;
      logic last_cell;
   } pos_flags_type;

endpackage

[rtl/alol_line_buf.sv]
// Line buffer of per-column run lengths with registered read and write-to-read forwarding.
module alol_line_buf import alol_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [RUN_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [RUN_W-1:0] rd_data
);

   logic [RUN_W-1:0] mem [DEPTH];
   logic [RUN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-edge write to the address being fetched returns the new value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/alol_scan_pos.sv]
// Size register and row/column scan position with neighbor-fetch address.
module alol_scan_pos import alol_pkg::*; #(
   parameter int MAX_SIZE = 64,
   parameter int CW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_we,
   input  logic [SIZE_W-1:0] cfg_data,
   input  logic              advance,
   output logic [CW-1:0]     col,
   output logic [CW-1:0]     fetch_addr,
   output pos_flags_type     flags
);

   localparam int ResetEff = (int'(SIZE_RESET) > MAX_SIZE) ? MAX_SIZE : int'(SIZE_RESET);

   logic [CW-1:0] last_ff, last_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   always_comb begin
      int unsigned eff;
      eff = int'(cfg_data);
      if (eff == 0) begin
         eff = 1;
      end
      if (eff > MAX_SIZE) begin
         eff = MAX_SIZE;
      end
      last_in = cfg_we ? CW'(eff - 1) : last_ff;
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cfg_we) begin
         row_in = '0;
         col_in = '0;
      end else if (advance) begin
         if (col_ff != last_ff) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            row_in = (row_ff != last_ff) ? row_ff + CW'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= CW'(ResetEff - 1);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         last_ff <= last_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   assign col = col_ff;
   assign fetch_addr = (col_ff != last_ff) ? col_ff + CW'(1) : '0;
   assign flags.top_row = (row_ff == '0);
   assign flags.last_col = (col_ff == last_ff);
   assign flags.last_cell = (col_ff == last_ff) && (row_ff == last_ff);

endmodule

[rtl/antidiagonal_longest_ones_run_core.sv]
// Top level: longest run of ones along anti-diagonals of a streamed square matrix.
// A result is registered after the last cell of a matrix passes the input stage.
// One cell per cycle when not stalled; line buffer: one read and one write per cycle.
// The request side stalls only while a finished result waits and the next result is ready.
// Reset (synchronous): size 8, scan position and best run cleared, no result pending.
// The line buffer needs no clearing; entries are used only after the row above wrote them.
module antidiagonal_longest_ones_run_core import alol_pkg::*; #(
   parameter int MAX_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cell_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [RUN_W-1:0]  rsp_longest_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_size_in_use
);

   localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

   logic             accept;
   logic             cfg_we;
   logic [CW-1:0]    pos_col;
   logic [CW-1:0]    fetch_addr;
   pos_flags_type    pos_flags;
   logic [RUN_W-1:0] up_right_run;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_cell_ff;
   logic [CW-1:0]    s1_col_ff;
   pos_flags_type    s1_flags_ff;
   logic             s1_fire;

   logic [RUN_W-1:0] prev_run;
   logic [RUN_W-1:0] run;
   logic [RUN_W-1:0] best_next;
   logic [RUN_W-1:0] best_ff, best_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0] rsp_run_ff;

   assign csr_ready = 1'b1;
   assign cfg_we = csr_valid && csr_ready;

   assign s1_fire = s1_valid_ff && !(s1_flags_ff.last_cell && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept = req_valid && !req_stall;

   alol_scan_pos #(
      .MAX_SIZE (MAX_SIZE),
      .CW       (CW)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (cfg_we),
      .cfg_data   (csr_size_in_use),
      .advance    (accept),
      .col        (pos_col),
      .fetch_addr (fetch_addr),
      .flags      (pos_flags)
   );

   alol_line_buf #(
      .DEPTH (MAX_SIZE),
      .AW    (CW)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (run),
      .rd_en   (accept),
      .rd_addr (fetch_addr),
      .rd_data (up_right_run)
   );

   always_comb begin
      prev_run = (s1_flags_ff.top_row || s1_flags_ff.last_col) ? '0 : up_right_run;
      if (!s1_cell_ff) begin
         run = '0;
      end else if (prev_run == RUN_CAP) begin
         run = RUN_CAP;
      end else begin
         run = prev_run + RUN_W'(1);
      end
      best_next = (run > best_ff) ? run : best_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      best_in = best_ff;
      if (cfg_we) begin
         best_in = '0;
      end else if (s1_fire) begin
         best_in = s1_flags_ff.last_cell ? '0 : best_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_flags_ff.last_cell) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff  <= req_cell_value;
         s1_col_ff   <= pos_col;
         s1_flags_ff <= pos_flags;
      end
      if (s1_fire && s1_flags_ff.last_cell) begin
         rsp_run_ff <= best_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_longest_run = rsp_run_ff;

endmodule

[rtl/alol_checker.sv]
// Port-level checker for the anti-diagonal longest-ones-run core, with its bind.
module alol_checker import alol_pkg::*; #(
   parameter int MAX_SIZE = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [RUN_W-1:0]  rsp_longest_run
);

   localparam int RunBound = (MAX_SIZE > int'(RUN_CAP)) ? int'(RUN_CAP) : MAX_SIZE;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_longest_run))
      else $error("stalled result changed");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_longest_run) <= RunBound))
      else $error("longest run exceeds matrix size");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a new result follows a request accepted through the input stage and result register
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a preceding request");

endmodule

bind antidiagonal_longest_ones_run_core alol_checker #(
   .MAX_SIZE (MAX_SIZE)
) u_alol_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_longest_run (rsp_longest_run)
);

[sim/tb_top.sv]
// Self-checking testbench for the anti-diagonal longest-ones-run core.
`timescale 1ns / 100ps

module tb_top import alol_pkg::*; ();

   localparam int MAX_SIZE = 64;
   localparam int SCAN_SLACK = 4;
   localparam int LONG_HOLD = 80;
   localparam int RANDOM_CELLS = 450;
   localparam int DRAIN_LIMIT = 5000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_cell_value = 1'b0;
   logic              rsp_stall = 1'b0;
   logic              csr_valid = 1'b0;
   logic [SIZE_W-1:0] csr_size_in_use = '0;
   wire               req_stall;
   wire               rsp_valid;
   wire               csr_ready;
   wire  [RUN_W-1:0]  rsp_longest_run;

   antidiagonal_longest_ones_run_core #(.MAX_SIZE(MAX_SIZE)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_longest_run (rsp_longest_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_size_in_use (csr_size_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scan tracker state
   logic [SIZE_W-1:0] size_reg = SIZE_RESET;
   logic [RUN_W-1:0]  column_runs [MAX_SIZE];
   int unsigned       scan_row = 0;
   int unsigned       scan_col = 0;
   int unsigned       best_so_far = 0;
   logic [RUN_W-1:0]  longest_run_q [$];

   int fail_count = 0;
   int mismatch_count = 0;
   int cells_sent = 0;
   bit burst_mode = 1'b0;
   bit hold_request = 1'b0;
   bit holding = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned edge_len();
      int unsigned n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
   endfunction

   function automatic void restart_scan();
      scan_row = 0;
      scan_col = 0;
      best_so_far = 0;
   endfunction

   function automatic void score_cell(bit cell_bit);
      int unsigned n;
      int unsigned run;
      n = edge_len();
      if (scan_row >= n || scan_col >= n) restart_scan();
      run = 0;
      if (cell_bit) begin
         if (scan_row > 0 && scan_col + 1 < n) run = column_runs[scan_col + 1] + 1;
         else run = 1;
         if (run > RUN_CAP) run = RUN_CAP;
      end
      column_runs[scan_col] = RUN_W'(run);
      if (run > best_so_far) best_so_far = run;
      if (scan_col + 1 < n) begin
         scan_col++;
      end else begin
         scan_col = 0;
         if (scan_row + 1 < n) begin
            scan_row++;
         end else begin
            longest_run_q.push_back(RUN_W'(best_so_far));
            restart_scan();
         end
      end
   endfunction

   task automatic send_cell(bit cell_bit);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_value <= cell_bit;
      do @(posedge clock); while (req_stall);
      score_cell(cell_bit);
      cells_sent++;
   endtask

   task automatic send_matrix(int unsigned n, int pct);
      repeat (n * n) send_cell($urandom_range(0, 99) < pct);
   endtask

   task automatic send_pattern(int count, logic [63:0] bits);
      for (int i = count - 1; i >= 0; i--) send_cell(bits[i]);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (longest_run_q.size() != 0) @(posedge clock);
      repeat (SCAN_SLACK) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_size_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      size_reg = value;
      restart_scan();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      logic [RUN_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (longest_run_q.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: longest_run %0d", rsp_longest_run);
         end else begin
            want = longest_run_q.pop_front();
            if (rsp_longest_run !== want) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("longest_run mismatch: expected %0d, got %0d", want,
                           rsp_longest_run);
            end
         end
      end
   end

   // result side stall
   initial begin
      int k;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            holding = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            holding = 1'b0;
         end else if (burst_mode) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            k = pick_gap();
            if (k > 0) begin
               rsp_stall <= 1'b1;
               repeat (k) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   task automatic test_reset_size();
      send_matrix(8, 70);
      wait_results_drained();
   endtask

   task automatic test_size_edges();
      write_size(7'd0);
      send_pattern(2, 64'b10);
      wait_results_drained();
      write_size(7'd1);
      send_cell(1'b1);
      wait_results_drained();
      write_size(7'd2);
      send_pattern(4, 64'b1111);
      wait_results_drained();
      write_size(7'd3);
      send_pattern(9, 64'b111_111_111);
      // runs must not carry across diagonals or from the last column
      send_pattern(9, 64'b011_110_001);
      wait_results_drained();
   endtask

   task automatic test_restart_mid_matrix();
      write_size(7'd4);
      send_pattern(6, 64'b111111);
      wait_results_drained();
      write_size(7'd2);
      send_pattern(4, 64'b1101);
      wait_results_drained();
      write_size(7'd4);
      send_pattern(3, 64'b111);
      wait_results_drained();
      write_size(7'd4);
      send_matrix(4, 60);
      wait_results_drained();
   endtask

   task automatic test_backpressure();
      wait_results_drained();
      write_size(7'd1);
      hold_request = 1'b1;
      while (!holding) @(posedge clock);
      burst_mode = 1'b1;
      repeat (30) send_cell(1'($urandom_range(0, 1)));
      burst_mode = 1'b0;
      wait_results_drained();
   endtask

   task automatic test_random();
      int stop_at;
      int r;
      int unsigned n;
      int mats;
      int pct;
      logic [SIZE_W-1:0] sz;
      stop_at = cells_sent + RANDOM_CELLS;
      while (cells_sent < stop_at) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 9);
         if (r == 0) sz = SIZE_W'($urandom_range(0, 127));
         else if (r <= 2) sz = SIZE_W'($urandom_range(9, 16));
         else sz = SIZE_W'($urandom_range(1, 8));
         wait_results_drained();
         write_size(sz);
         n = edge_len();
         if (n > 16) begin
            repeat ($urandom_range(1, 40)) send_cell(1'($urandom_range(0, 1)));
         end else begin
            mats = $urandom_range(1, 4);
            for (int m = 0; m < mats; m++) begin
               case ($urandom_range(0, 3))
                  0: pct = 10;
                  1: pct = 50;
                  2: pct = 80;
                  default: pct = 95;
               endcase
               if ($urandom_range(0, 7) == 0) begin
                  repeat ($urandom_range(0, n * n - 1)) send_cell($urandom_range(0, 99) < pct);
                  break;
               end
               send_matrix(n, pct);
            end
         end
      end
      burst_mode = 1'b0;
      wait_results_drained();
   endtask

   task automatic test_large_sizes();
      write_size(7'd64);
      repeat (2 * 64) send_cell($urandom_range(0, 99) < 90);
      wait_results_drained();
      write_size(7'd127);
      repeat (2 * 64) send_cell($urandom_range(0, 99) < 90);
      wait_results_drained();
      write_size(7'd20);
      send_matrix(20, 100);
      wait_results_drained();
   endtask

   initial begin
      int waited;
      foreach (column_runs[i]) column_runs[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size();
      test_size_edges();
      test_restart_mid_matrix();
      test_backpressure();
      test_random();
      test_large_sizes();
      req_valid <= 1'b0;
      waited = 0;
      while (longest_run_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (longest_run_q.size() != 0) begin
         $display("%0d expected results never arrived", longest_run_q.size());
         fail_count += longest_run_q.size();
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
